/* hdl/olist_pkg.sv */
// Shared types, codes and constants for the ordered list engine.
// Used by olist_cell and ordered_list_engine_core; depends on nothing else.
`default_nettype none

package olist_pkg;

    localparam int CAPACITY_DEF = 32;
    localparam int DATA_W       = 32;
    localparam int LENGTH_W     = 6;

    localparam logic [2:0] FN_INS_FRONT = 3'd0;
    localparam logic [2:0] FN_INS_BACK  = 3'd1;
    localparam logic [2:0] FN_INS_AFTER = 3'd2;
    localparam logic [2:0] FN_DEL_FRONT = 3'd3;
    localparam logic [2:0] FN_DEL_BACK  = 3'd4;
    localparam logic [2:0] FN_DEL_VALUE = 3'd5;
    localparam logic [2:0] FN_DUMP      = 3'd6;
    localparam logic [2:0] FN_CLEAR     = 3'd7;

    localparam logic [1:0] STAT_OK       = 2'd0;
    localparam logic [1:0] STAT_EMPTY    = 2'd1;
    localparam logic [1:0] STAT_NOTFOUND = 2'd2;
    localparam logic [1:0] STAT_FULL     = 2'd3;

    localparam logic [1:0] OP_HOLD   = 2'd0;
    localparam logic [1:0] OP_INSERT = 2'd1;
    localparam logic [1:0] OP_REMOVE = 2'd2;
    localparam logic [1:0] OP_ROTATE = 2'd3;

    localparam logic [1:0] GE_ALL       = 2'd0;
    localparam logic [1:0] GE_AT_LEN    = 2'd1;
    localparam logic [1:0] GE_AFTER_HIT = 2'd2;
    localparam logic [1:0] GE_AT_HIT    = 2'd3;

    typedef struct packed {
        logic        [2:0]        func;
        logic signed [DATA_W-1:0] value;
        logic signed [DATA_W-1:0] target;
    } olist_cmd_t;

    typedef struct packed {
        logic        [1:0]          status;
        logic signed [DATA_W-1:0]   element;
        logic                       element_valid;
        logic        [LENGTH_W-1:0] length;
        logic                       last;
    } olist_rsp_t;

    typedef struct packed {
        logic [1:0]        op;
        logic [1:0]        ge_mode;
        logic              cmp;
        logic [DATA_W-1:0] key;
        logic [DATA_W-1:0] new_value;
    } olist_cell_ctrl_t;

endpackage

`default_nettype wire

/* hdl/olist_cell.sv */
// One list cell: holds one element, compares it against a key and shifts
// toward either neighbor. Depends on olist_pkg.
`default_nettype none

module olist_cell #(
    parameter int INDEX = 0,
    parameter int LEN_W = 6
) (
    input  wire                              clk,
    input  wire                              rst_n,
    input  olist_pkg::olist_cell_ctrl_t      ctrl,
    input  wire [LEN_W-1:0]                  len,
    input  wire [olist_pkg::DATA_W-1:0]      left_value,
    input  wire [olist_pkg::DATA_W-1:0]      right_value,
    input  wire [olist_pkg::DATA_W-1:0]      wrap_value,
    input  wire                              ge_prev,
    input  wire                              seen_in,
    output logic [olist_pkg::DATA_W-1:0]     value,
    output logic                             ge,
    output logic                             seen_out
);
    import olist_pkg::*;

    logic [DATA_W-1:0] value_reg;
    logic [DATA_W-1:0] value_next;
    logic              hit_reg;
    logic              hit_next;
    logic              in_list;
    logic              is_tail;
    logic              is_pos;

    assign in_list  = LEN_W'(INDEX) < len;
    assign is_tail  = LEN_W'(INDEX) == (len - LEN_W'(1));
    assign hit_next = in_list && (value_reg == ctrl.key);
    assign seen_out = seen_in | hit_reg;
    assign is_pos   = ge & ~ge_prev;
    assign value    = value_reg;

    always_comb
    begin
        case (ctrl.ge_mode)
            GE_ALL:       ge = 1'b1;
            GE_AT_LEN:    ge = ~in_list;
            GE_AFTER_HIT: ge = seen_in;
            GE_AT_HIT:    ge = seen_in | hit_reg;
            default:      ge = 1'b0;
        endcase
    end

    always_comb
    begin
        case (ctrl.op)
            OP_INSERT:
            begin
                if (is_pos)
                    value_next = ctrl.new_value;
                else if (ge)
                    value_next = left_value;
                else
                    value_next = value_reg;
            end
            OP_REMOVE:  value_next = ge ? right_value : value_reg;
            OP_ROTATE:
            begin
                if (is_tail)
                    value_next = wrap_value;
                else if (in_list)
                    value_next = right_value;
                else
                    value_next = value_reg;
            end
            default:    value_next = value_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            hit_reg <= 1'b0;
        else if (ctrl.cmp)
            hit_reg <= hit_next;
    end

endmodule

`default_nettype wire

/* hdl/ordered_list_engine_core.sv */
// Top level of the ordered list engine: command sequencer, result register
// and the chain of olist_cell instances. Depends on olist_pkg and olist_cell.
//
//  Channel | Direction | Handshake            | Payload
//  cmd     | in        | cmd_valid/cmd_ready  | olist_cmd_t (func, value, target)
//  rsp     | out       | rsp_valid/rsp_ready  | olist_rsp_t (status .. last)
//
// Inserts, front/back deletes and clear go from S_IDLE to S_EXEC; insert after and
// delete value pass through S_CMP first, for the parallel compare in every cell.
// A non-empty dump returns its elements one by one in S_DUMP, set by the rotation
// of the chain that brings each element to cell 0. After reset the list is empty.
// A stalled result register holds the sequencer until it is taken.
`default_nettype none

module ordered_list_engine_core #(
    parameter int CAPACITY = olist_pkg::CAPACITY_DEF
) (
    input  wire                    clk,
    input  wire                    rst_n,
    input  wire                    cmd_valid,
    output logic                   cmd_ready,
    input  olist_pkg::olist_cmd_t  cmd,
    output logic                   rsp_valid,
    input  wire                    rsp_ready,
    output olist_pkg::olist_rsp_t  rsp
);
    import olist_pkg::*;

    localparam int LW = $clog2(CAPACITY + 1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_CMP  = 2'd1;
    localparam logic [1:0] S_EXEC = 2'd2;
    localparam logic [1:0] S_DUMP = 2'd3;

    logic [1:0]       state_reg;
    logic [1:0]       state_next;
    olist_cmd_t       cmd_reg;
    logic [LW-1:0]    len_reg;
    logic [LW-1:0]    len_next;
    logic [LW-1:0]    cnt_reg;
    logic [LW-1:0]    cnt_next;
    logic             rsp_valid_reg;
    logic             rsp_valid_next;
    olist_rsp_t       rsp_reg;
    olist_rsp_t       rsp_next;
    olist_cell_ctrl_t ctrl;

    logic [DATA_W-1:0] cell_value [CAPACITY];
    logic              cell_ge    [CAPACITY];
    logic              cell_seen  [CAPACITY];

    logic          out_free;
    logic          full;
    logic          empty;
    logic          found;
    logic          dump_last;
    logic [1:0]    status;
    logic [LW-1:0] len_after;

    assign cmd_ready = (state_reg == S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;
    assign out_free  = !rsp_valid_reg || rsp_ready;
    assign full      = (len_reg == LW'(CAPACITY));
    assign empty     = (len_reg == '0);
    assign found     = cell_seen[CAPACITY-1];
    assign dump_last = (cnt_reg == (len_reg - LW'(1)));

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++)
        begin : g_cell
            logic [DATA_W-1:0] left_value;
            logic [DATA_W-1:0] right_value;
            logic              ge_prev;
            logic              seen_in;

            if (g == 0)
            begin : g_head
                assign left_value = '0;
                assign ge_prev    = 1'b0;
                assign seen_in    = 1'b0;
            end
            else
            begin : g_body
                assign left_value = cell_value[g-1];
                assign ge_prev    = cell_ge[g-1];
                assign seen_in    = cell_seen[g-1];
            end

            if (g == CAPACITY - 1)
            begin : g_tail
                assign right_value = cell_value[g];
            end
            else
            begin : g_mid
                assign right_value = cell_value[g+1];
            end

            olist_cell #(
                .INDEX (g),
                .LEN_W (LW)
            ) u_cell (
                .clk         (clk),
                .rst_n       (rst_n),
                .ctrl        (ctrl),
                .len         (len_reg),
                .left_value  (left_value),
                .right_value (right_value),
                .wrap_value  (cell_value[0]),
                .ge_prev     (ge_prev),
                .seen_in     (seen_in),
                .value       (cell_value[g]),
                .ge          (cell_ge[g]),
                .seen_out    (cell_seen[g])
            );
        end
    endgenerate

    always_comb
    begin
        status    = STAT_OK;
        len_after = len_reg;
        ctrl      = '{op: OP_HOLD, ge_mode: GE_ALL, cmp: 1'b0,
                      key: cmd_reg.value, new_value: cmd_reg.value};

        case (cmd_reg.func)
            FN_INS_FRONT, FN_INS_BACK:
            begin
                if (full)
                    status = STAT_FULL;
                else
                begin
                    ctrl.op      = OP_INSERT;
                    ctrl.ge_mode = (cmd_reg.func == FN_INS_FRONT) ? GE_ALL : GE_AT_LEN;
                    len_after    = len_reg + LW'(1);
                end
            end
            FN_INS_AFTER:
            begin
                if (empty)
                    status = STAT_EMPTY;
                else if (!found)
                    status = STAT_NOTFOUND;
                else if (full)
                    status = STAT_FULL;
                else
                begin
                    ctrl.op      = OP_INSERT;
                    ctrl.ge_mode = GE_AFTER_HIT;
                    len_after    = len_reg + LW'(1);
                end
            end
            FN_DEL_FRONT:
            begin
                if (empty)
                    status = STAT_EMPTY;
                else
                begin
                    ctrl.op   = OP_REMOVE;
                    len_after = len_reg - LW'(1);
                end
            end
            FN_DEL_BACK:
            begin
                if (empty)
                    status = STAT_EMPTY;
                else
                    len_after = len_reg - LW'(1);
            end
            FN_DEL_VALUE:
            begin
                if (empty)
                    status = STAT_EMPTY;
                else if (!found)
                    status = STAT_NOTFOUND;
                else
                begin
                    ctrl.op      = OP_REMOVE;
                    ctrl.ge_mode = GE_AT_HIT;
                    len_after    = len_reg - LW'(1);
                end
            end
            FN_DUMP:
            begin
                if (empty)
                    status = STAT_EMPTY;
            end
            default:
            begin
                len_after = '0;
            end
        endcase

        if (state_reg == S_CMP)
        begin
            ctrl      = '{op: OP_HOLD, ge_mode: GE_ALL, cmp: 1'b1,
                          key: (cmd_reg.func == FN_INS_AFTER) ? cmd_reg.target
                                                              : cmd_reg.value,
                          new_value: cmd_reg.value};
        end
        else if (state_reg == S_DUMP)
        begin
            ctrl.op = out_free ? OP_ROTATE : OP_HOLD;
        end
        else if (state_reg != S_EXEC || !out_free)
        begin
            ctrl.op = OP_HOLD;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        len_next       = len_reg;
        cnt_next       = cnt_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        rsp_next       = rsp_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    if (cmd.func == FN_INS_AFTER || cmd.func == FN_DEL_VALUE)
                        state_next = S_CMP;
                    else
                        state_next = S_EXEC;
                end
            end
            S_CMP:
            begin
                state_next = S_EXEC;
            end
            S_EXEC:
            begin
                if (cmd_reg.func == FN_DUMP && !empty)
                begin
                    cnt_next   = '0;
                    state_next = S_DUMP;
                end
                else if (out_free)
                begin
                    len_next       = len_after;
                    rsp_valid_next = 1'b1;
                    rsp_next       = '{status: status, element: '0, element_valid: 1'b0,
                                       length: LENGTH_W'(len_after), last: 1'b1};
                    state_next     = S_IDLE;
                end
            end
            S_DUMP:
            begin
                if (out_free)
                begin
                    rsp_valid_next = 1'b1;
                    rsp_next       = '{status: STAT_OK, element: cell_value[0],
                                       element_valid: 1'b1,
                                       length: LENGTH_W'(len_reg), last: dump_last};
                    cnt_next       = cnt_reg + LW'(1);
                    if (dump_last)
                        state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            len_reg       <= '0;
            cnt_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            len_reg       <= len_next;
            cnt_reg       <= cnt_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
        if (cmd_valid && cmd_ready)
            cmd_reg <= cmd;
    end

endmodule

`default_nettype wire

/* tb/tb.sv */
// Self-checking testbench for ordered_list_engine_core, the bounded ordered list.
// Depends on olist_pkg and the engine RTL. It runs a directed table, then random
// command sequences checked against a predictor of the list.
`timescale 1ns / 100ps

module tb;
    import olist_pkg::*;

    localparam int LIST_CAP    = CAPACITY_DEF;
    localparam int DIR_ROWS    = 25;
    localparam int PHASE_ITEMS = 130;
    localparam int CYCLE_LIMIT = 800000;

    typedef struct packed {
        logic [2:0]          func;
        logic [DATA_W-1:0]   value;
        logic [DATA_W-1:0]   target;
        logic                typed;
        logic [1:0]          status;
        logic [LENGTH_W-1:0] length;
    } dir_row_t;

    logic       clk;
    logic       rst_n = 1'b0;
    logic       cmd_valid = 1'b0;
    logic       cmd_ready;
    olist_cmd_t cmd = '0;
    logic       rsp_valid;
    logic       rsp_ready = 1'b0;
    olist_rsp_t rsp;

    logic [DATA_W-1:0] list_cells [LIST_CAP];
    int                list_len = 0;
    olist_rsp_t        expected_rsps [$];
    olist_rsp_t        oldest_rsp;
    dir_row_t          dir_rows [DIR_ROWS];

    int send_idle_pct = 22;
    int recv_idle_pct = 74;
    int error_count = 0;
    int cmd_count = 0;
    int rsp_count = 0;
    int full_count = 0;
    int dump_count = 0;
    int cycle_count = 0;

    ordered_list_engine_core #(
        .CAPACITY (LIST_CAP)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("tb: FAIL");
            $finish;
        end
    end

    function automatic void open_slot(input int pos, input logic [DATA_W-1:0] v);
        for (int i = list_len; i > pos; i--)
            list_cells[i] = list_cells[i - 1];
        list_cells[pos] = v;
        list_len++;
    endfunction

    function automatic void close_slot(input int pos);
        for (int i = pos; i + 1 < list_len; i++)
            list_cells[i] = list_cells[i + 1];
        list_len--;
    endfunction

    function automatic int find_first(input logic [DATA_W-1:0] v);
        for (int i = 0; i < list_len; i++)
            if (list_cells[i] == v)
                return i;
        return list_len;
    endfunction

    function automatic void push_result(input logic [1:0] st, input logic [DATA_W-1:0] elem,
                                        input logic elem_valid, input logic is_last);
        olist_rsp_t r;
        r = '0;
        r.status = st;
        r.element = elem;
        r.element_valid = elem_valid;
        r.length = LENGTH_W'(list_len);
        r.last = is_last;
        expected_rsps.push_back(r);
    endfunction

    function automatic void apply_command(input olist_cmd_t c);
        logic [1:0] st;
        int         hit;
        st = STAT_OK;
        case (c.func)
            FN_INS_FRONT:
                if (list_len >= LIST_CAP) st = STAT_FULL;
                else open_slot(0, c.value);
            FN_INS_BACK:
                if (list_len >= LIST_CAP) st = STAT_FULL;
                else open_slot(list_len, c.value);
            FN_INS_AFTER:
                if (list_len == 0) st = STAT_EMPTY;
                else
                begin
                    hit = find_first(c.target);
                    if (hit >= list_len) st = STAT_NOTFOUND;
                    else if (list_len >= LIST_CAP) st = STAT_FULL;
                    else open_slot(hit + 1, c.value);
                end
            FN_DEL_FRONT:
                if (list_len == 0) st = STAT_EMPTY;
                else close_slot(0);
            FN_DEL_BACK:
                if (list_len == 0) st = STAT_EMPTY;
                else list_len--;
            FN_DEL_VALUE:
                if (list_len == 0) st = STAT_EMPTY;
                else
                begin
                    hit = find_first(c.value);
                    if (hit >= list_len) st = STAT_NOTFOUND;
                    else close_slot(hit);
                end
            FN_DUMP:
            begin
                dump_count++;
                if (list_len == 0)
                    push_result(STAT_EMPTY, '0, 1'b0, 1'b1);
                else
                    for (int i = 0; i < list_len; i++)
                        push_result(STAT_OK, list_cells[i], 1'b1, i + 1 == list_len);
                return;
            end
            FN_CLEAR:
                list_len = 0;
        endcase
        if (st == STAT_FULL)
            full_count++;
        push_result(st, '0, 1'b0, 1'b1);
    endfunction

    always @(posedge clk)
    begin
        if (!rst_n)
            rsp_ready <= 1'b0;
        else
        begin
            if (rsp_valid && rsp_ready)
            begin
                if (expected_rsps.size() == 0)
                begin
                    $error("unexpected result: status %0d element %0d length %0d",
                           rsp.status, rsp.element, rsp.length);
                    error_count++;
                end
                else
                begin
                    oldest_rsp = expected_rsps.pop_front();
                    rsp_count++;
                    if (rsp.status !== oldest_rsp.status)
                    begin
                        $error("status: expected %0d, got %0d", oldest_rsp.status, rsp.status);
                        error_count++;
                    end
                    if (rsp.element !== oldest_rsp.element)
                    begin
                        $error("element: expected %0d, got %0d",
                               oldest_rsp.element, rsp.element);
                        error_count++;
                    end
                    if (rsp.element_valid !== oldest_rsp.element_valid)
                    begin
                        $error("element_valid: expected %0d, got %0d",
                               oldest_rsp.element_valid, rsp.element_valid);
                        error_count++;
                    end
                    if (rsp.length !== oldest_rsp.length)
                    begin
                        $error("length: expected %0d, got %0d", oldest_rsp.length, rsp.length);
                        error_count++;
                    end
                    if (rsp.last !== oldest_rsp.last)
                    begin
                        $error("last: expected %0d, got %0d", oldest_rsp.last, rsp.last);
                        error_count++;
                    end
                end
            end
            rsp_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    task automatic issue(input olist_cmd_t c, input logic typed, input logic [1:0] t_status,
                         input logic [LENGTH_W-1:0] t_length);
        olist_rsp_t fixed;
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            cmd_valid <= 1'b0;
            @(posedge clk);
        end
        cmd_valid <= 1'b1;
        cmd <= c;
        do
            @(posedge clk);
        while (!cmd_ready);
        cmd_count++;
        apply_command(c);
        if (typed)
        begin
            fixed = '0;
            fixed.status = t_status;
            fixed.length = t_length;
            fixed.last = 1'b1;
            expected_rsps[expected_rsps.size() - 1] = fixed;
        end
    endtask

    task automatic hold_until_drained();
        cmd_valid <= 1'b0;
        do
            @(posedge clk);
        while (expected_rsps.size() != 0);
    endtask

    function automatic logic [DATA_W-1:0] pick_value();
        case ($urandom_range(0, 11))
            0: return 32'h0000_0000;
            1: return 32'hFFFF_FFFF;
            2: return 32'h7FFF_FFFF;
            3: return 32'h8000_0000;
            4: return 32'h0000_0001;
            5: return 32'h5555_5555;
            6: return 32'hAAAA_AAAA;
            7: return 32'h0000_0005;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [DATA_W-1:0] pick_known();
        if (list_len > 0 && $urandom_range(0, 9) < 7)
            return list_cells[$urandom_range(0, list_len - 1)];
        return pick_value();
    endfunction

    function automatic olist_cmd_t noise_cmd();
        olist_cmd_t c;
        c.func = 3'($urandom_range(0, 7));
        c.value = $urandom;
        c.target = $urandom;
        return c;
    endfunction

    function automatic olist_cmd_t make_insert();
        olist_cmd_t c;
        c = noise_cmd();
        case ($urandom_range(0, 2))
            0: c.func = FN_INS_FRONT;
            1: c.func = FN_INS_BACK;
            default: c.func = FN_INS_AFTER;
        endcase
        c.value = pick_value();
        c.target = pick_known();
        return c;
    endfunction

    function automatic olist_cmd_t make_delete();
        olist_cmd_t c;
        c = noise_cmd();
        case ($urandom_range(0, 2))
            0: c.func = FN_DEL_FRONT;
            1: c.func = FN_DEL_BACK;
            default: c.func = FN_DEL_VALUE;
        endcase
        c.value = pick_known();
        return c;
    endfunction

    task automatic run_random(input int quota);
        olist_cmd_t c;
        int         sent;
        int         kind;
        int         n;
        sent = 0;
        while (sent < quota)
        begin
            kind = $urandom_range(0, 9);
            if (kind < 3)
                n = LIST_CAP - list_len + $urandom_range(1, 3);
            else if (kind < 5)
                n = list_len + $urandom_range(0, 2);
            else if (kind < 9)
                n = 8;
            else
                n = 4;
            for (int i = 0; i < n; i++)
            begin
                if (kind < 3)
                    c = make_insert();
                else if (kind < 5)
                    c = make_delete();
                else if (kind < 9)
                begin
                    case ($urandom_range(0, 19))
                        0, 1, 2, 3, 4, 5, 6, 7: c = make_insert();
                        8, 9, 10, 11, 12, 13, 14: c = make_delete();
                        15, 16, 17:
                        begin
                            c = noise_cmd();
                            c.func = FN_DUMP;
                        end
                        default:
                        begin
                            c = noise_cmd();
                            c.func = FN_CLEAR;
                        end
                    endcase
                end
                else
                    c = noise_cmd();
                issue(c, 1'b0, STAT_OK, '0);
                sent++;
            end
            if (kind < 5)
            begin
                c = noise_cmd();
                c.func = FN_DUMP;
                issue(c, 1'b0, STAT_OK, '0);
                sent++;
            end
        end
    endtask

    initial
    begin
        olist_cmd_t c;
        dir_rows = '{
            '{FN_DUMP,      32'h0000_0000, 32'h0000_0000, 1'b1, STAT_EMPTY,    6'd0},
            '{FN_DEL_FRONT, 32'h0000_0000, 32'h0000_0000, 1'b1, STAT_EMPTY,    6'd0},
            '{FN_DEL_BACK,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, STAT_EMPTY,    6'd0},
            '{FN_DEL_VALUE, 32'h0000_0000, 32'h0000_0000, 1'b1, STAT_EMPTY,    6'd0},
            '{FN_INS_AFTER, 32'h0000_0001, 32'h0000_0000, 1'b1, STAT_EMPTY,    6'd0},
            '{FN_CLEAR,     32'h0000_0000, 32'h0000_0000, 1'b1, STAT_OK,       6'd0},
            '{FN_INS_BACK,  32'h7FFF_FFFF, 32'h0000_0000, 1'b1, STAT_OK,       6'd1},
            '{FN_INS_FRONT, 32'h8000_0000, 32'h0000_0000, 1'b1, STAT_OK,       6'd2},
            '{FN_INS_BACK,  32'hFFFF_FFFF, 32'h8000_0000, 1'b1, STAT_OK,       6'd3},
            '{FN_INS_AFTER, 32'h0000_0000, 32'h8000_0000, 1'b0, STAT_OK,       6'd0},
            '{FN_INS_AFTER, 32'h0000_0005, 32'h0000_3039, 1'b1, STAT_NOTFOUND, 6'd4},
            '{FN_INS_AFTER, 32'h0000_0007, 32'hFFFF_FFFF, 1'b0, STAT_OK,       6'd0},
            '{FN_INS_AFTER, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0, STAT_OK,       6'd0},
            '{FN_DUMP,      32'h0000_0000, 32'h0000_0000, 1'b0, STAT_OK,       6'd0},
            '{FN_DEL_VALUE, 32'h7FFF_FFFF, 32'h0000_0000, 1'b0, STAT_OK,       6'd0},
            '{FN_DEL_VALUE, 32'h7FFF_FFFE, 32'h7FFF_FFFF, 1'b1, STAT_NOTFOUND, 6'd5},
            '{FN_DEL_VALUE, 32'h0000_0000, 32'h0000_0000, 1'b0, STAT_OK,       6'd0},
            '{FN_DEL_FRONT, 32'h0000_0000, 32'h0000_0000, 1'b0, STAT_OK,       6'd0},
            '{FN_DEL_BACK,  32'h0000_0000, 32'h0000_0000, 1'b0, STAT_OK,       6'd0},
            '{FN_DUMP,      32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, STAT_OK,       6'd0},
            '{FN_CLEAR,     32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, STAT_OK,       6'd0},
            '{FN_DUMP,      32'h0000_0000, 32'h0000_0000, 1'b1, STAT_EMPTY,    6'd0},
            '{FN_INS_FRONT, 32'h5555_5555, 32'hAAAA_AAAA, 1'b0, STAT_OK,       6'd0},
            '{FN_INS_BACK,  32'hAAAA_AAAA, 32'h5555_5555, 1'b0, STAT_OK,       6'd0},
            '{FN_DUMP,      32'h0000_0000, 32'h0000_0000, 1'b0, STAT_OK,       6'd0}
        };
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        for (int phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:
                begin
                    send_idle_pct = 22;
                    recv_idle_pct = 74;
                end
                1:
                begin
                    send_idle_pct = 74;
                    recv_idle_pct = 22;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            if (phase == 0)
            begin
                for (int r = 0; r < DIR_ROWS; r++)
                begin
                    c.func = dir_rows[r].func;
                    c.value = dir_rows[r].value;
                    c.target = dir_rows[r].target;
                    issue(c, dir_rows[r].typed, dir_rows[r].status, dir_rows[r].length);
                end
            end
            run_random(PHASE_ITEMS);
            hold_until_drained();
        end
        repeat (2 * LIST_CAP + 16) @(posedge clk);
        $display("tb: %0d commands sent, %0d results checked", cmd_count, rsp_count);
        $display("tb: %0d dumps, %0d inserts refused on a full list", dump_count, full_count);
        if (error_count == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

endmodule
